FILE: hdl/des_rkg_pkg.sv
// DES key schedule package: PC-1 / PC-2 selection tables, rotate schedule,
// and helper functions. No dependencies.
`default_nettype none
package des_rkg_pkg;

  localparam int KEY_W   = 64;
  localparam int HALF_W  = 28;
  localparam int CD_W    = 2 * HALF_W;
  localparam int RK_W    = 48;
  localparam int RND_W   = 4;
  localparam logic [RND_W-1:0] LAST_ROUND = 4'd15;

  typedef logic [HALF_W-1:0] half_t;

  // Source bit positions, numbered from 1 at the MSB (FIPS 46 convention).
  localparam logic [6:0] PC1_TAB [CD_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [RK_W] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Single-place rotate in rounds 1, 2, 9 and 16 (indexes 0, 1, 8, 15).
  function automatic logic single_shift(input logic [RND_W-1:0] rnd);
    single_shift = (rnd == 4'd0) || (rnd == 4'd1) || (rnd == 4'd8) || (rnd == 4'd15);
  endfunction

  function automatic half_t rotl28(input half_t x, input logic one);
    rotl28 = one ? {x[HALF_W-2:0], x[HALF_W-1]} : {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]};
  endfunction

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] cd;
    cd = '0;
    for (int i = 0; i < CD_W; i++) begin
      cd[CD_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
    end
    pc1 = cd;
  endfunction

  function automatic logic [RK_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [RK_W-1:0] rk;
    rk = '0;
    for (int i = 0; i < RK_W; i++) begin
      rk[RK_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
    end
    pc2 = rk;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/des_round_key_generator.sv
// DES round-key generator top level: key register, per-round rotate, PC-2 output register.
// Depends on des_rkg_pkg.
//
// Takes one 64-bit DES key per transfer and delivers its sixteen 48-bit round keys in
// order, one per cycle while out_ready is high, each tagged with round_number (0..15)
// and last_round on the sixteenth. Parity bits are ignored. The C/D half registers
// rotate once per emitted subkey, and the next key is taken in the same cycle that the
// sixteenth subkey moves into the output register, so a stream of keys runs with no
// gap. Backpressure on out_ready stalls the rotation.
`default_nettype none
module des_round_key_generator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [des_rkg_pkg::KEY_W-1:0] in_key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [des_rkg_pkg::RK_W-1:0]       out_round_key,
  output logic [des_rkg_pkg::RND_W-1:0]      out_round_number,
  output logic                               out_last_round
);
  import des_rkg_pkg::*;

  logic              busy_r;
  logic [RND_W-1:0]  round_r;
  half_t             c_r, d_r;
  logic              out_valid_r;
  logic [RK_W-1:0]   rk_r;
  logic [RND_W-1:0]  num_r;
  logic              last_r;

  logic              advance;
  logic              in_xfer;
  logic              one;
  half_t             c_nxt, d_nxt;
  logic [CD_W-1:0]   cd_init;

  assign advance  = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (advance && (round_r == LAST_ROUND));
  assign in_xfer  = in_valid && in_ready;

  assign one     = single_shift(round_r);
  assign c_nxt   = rotl28(c_r, one);
  assign d_nxt   = rotl28(d_r, one);
  assign cd_init = pc1(in_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        busy_r  <= 1'b1;
        round_r <= '0;
      end else if (advance) begin
        round_r <= round_r + 4'd1;
        if (round_r == LAST_ROUND) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      c_r <= cd_init[CD_W-1:HALF_W];
      d_r <= cd_init[HALF_W-1:0];
    end else if (advance) begin
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
    if (advance) begin
      rk_r   <= pc2({c_nxt, d_nxt});
      num_r  <= round_r;
      last_r <= (round_r == LAST_ROUND);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_round_key    = rk_r;
  assign out_round_number = num_r;
  assign out_last_round   = last_r;

  // A new key always starts at round 0 with the schedule running.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> busy_r && (round_r == '0))
    else $error("key transfer did not start schedule");

  // Until the sixteenth subkey goes out, the schedule must still be running.
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_round |=> busy_r || out_valid)
    else $error("schedule stopped before last round");

  // Last flag only on round 16.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_round == (out_round_number == LAST_ROUND)))
    else $error("last_round flag mismatch");

  // Subkeys are numbered consecutively within a key.
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    advance && $past(advance) && !$past(in_xfer) && rst_n && $past(rst_n)
      |=> num_r == $past(num_r) + 4'd1)
    else $error("round number out of sequence");

endmodule
`default_nettype wire
